// ===== rtl/hva_pkg.sv =====
// Shared types, codes and a helper function for the homogeneous vector ALU.
`default_nettype none
package hva_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned SqrtStages = 32;

  typedef enum logic [3:0] {
    FUNC_ADD   = 4'd0,
    FUNC_SUB   = 4'd1,
    FUNC_NEG   = 4'd2,
    FUNC_SCALE = 4'd3,
    FUNC_DIV   = 4'd4,
    FUNC_DOT   = 4'd5,
    FUNC_CROSS = 4'd6,
    FUNC_MAG   = 4'd7,
    FUNC_NORM  = 4'd8
  } func_e;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] scale_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic signed [31:0] scalar_out;
    logic               a_is_point;
    logic               a_is_vector;
    logic               zero_divide;
    logic               saturated;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clip_t;

  function automatic clip_t clip66(input logic signed [65:0] v);
    clip_t c;
    c.sat = 1'b1;
    if (v > 66'sh7FFFFFFF) begin
      c.val = 32'sh7FFFFFFF;
    end else if (v < $signed(66'h3FFFFFFFF80000000)) begin
      c.val = 32'sh80000000;
    end else begin
      c.val = v[31:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hva_lane.sv =====
// One arithmetic lane: products, rounding and the element-wise operations.
`default_nettype none
module hva_lane import hva_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic               clk_i,
  input  logic [3:0]         func_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] m1a_i,
  input  logic signed [31:0] m1b_i,
  input  logic signed [31:0] m2a_i,
  input  logic signed [31:0] m2b_i,
  output logic signed [65:0] raw_o,
  output logic signed [65:0] rnd_o,
  output logic [63:0]        sq_o
);

  localparam logic signed [65:0] Half = 66'sd1 <<< (FracBits - 1);

  logic [3:0]         func_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [65:0] rnd1, rnd2, raw_d;
  logic signed [65:0] raw_q, rnd_q;
  logic [63:0]        sq_q;

  always_ff @(posedge clk_i) begin
    func_q <= func_i;
    a_q    <= a_i;
    b_q    <= b_i;
    p1_q   <= m1a_i * m1b_i;
    p2_q   <= m2a_i * m2b_i;
  end

  always_comb begin
    rnd1 = (66'(p1_q) + Half) >>> FracBits;
    rnd2 = (66'(p2_q) + Half) >>> FracBits;
    case (func_q)
      FUNC_ADD:   raw_d = 66'(a_q) + 66'(b_q);
      FUNC_SUB:   raw_d = 66'(a_q) - 66'(b_q);
      FUNC_NEG:   raw_d = -66'(a_q);
      FUNC_SCALE: raw_d = rnd1;
      FUNC_CROSS: raw_d = rnd1 - rnd2;
      default:    raw_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
    rnd_q <= rnd1;
    sq_q  <= p1_q[63:0];
  end

  assign raw_o = raw_q;
  assign rnd_o = rnd_q;
  assign sq_o  = sq_q;

endmodule
`default_nettype wire

// ===== rtl/hva_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module hva_sqrt import hva_pkg::*; (
  input  logic        clk_i,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);

  logic [63:0] n_q    [SqrtStages];
  logic [33:0] rem_q  [SqrtStages];
  logic [31:0] root_q [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic [63:0] n_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] trial, tst;
    logic        ge;
    if (k == 0) begin : g_first
      assign n_in    = n_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end
    assign trial = {rem_in, n_in[63:62]};
    assign tst   = {2'b00, root_in, 2'b01};
    assign ge    = trial >= tst;
    always_ff @(posedge clk_i) begin
      n_q[k]    <= {n_in[61:0], 2'b00};
      rem_q[k]  <= ge ? 34'(trial - tst) : trial[33:0];
      root_q[k] <= {root_in[30:0], ge};
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule
`default_nettype wire

// ===== rtl/hva_div.sv =====
// Pipelined restoring divider for one lane, one quotient bit per stage.
`default_nettype none
module hva_div import hva_pkg::*; #(
  parameter int unsigned NumBits = 32 + FracBitsDef
) (
  input  logic               clk_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [32:0]        den_i,
  output logic [NumBits-1:0] quo_o
);

  logic [NumBits-1:0] num_q [NumBits];
  logic [NumBits-1:0] quo_q [NumBits];
  logic [32:0]        rem_q [NumBits];
  logic [32:0]        den_q [NumBits];

  for (genvar k = 0; k < NumBits; k++) begin : g_stage
    logic [NumBits-1:0] num_in, quo_in;
    logic [32:0]        rem_in, den_in;
    logic [33:0]        trial;
    logic               ge;
    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end
    assign trial = {rem_in, num_in[NumBits-1]};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      num_q[k] <= num_in << 1;
      quo_q[k] <= {quo_in[NumBits-2:0], ge};
      rem_q[k] <= ge ? 33'(trial - {1'b0, den_in}) : trial[32:0];
      den_q[k] <= den_in;
    end
  end

  assign quo_o = quo_q[NumBits-1];

endmodule
`default_nettype wire

// ===== rtl/homogeneous_vector_alu.sv =====
// Top level of the homogeneous four-component vector ALU.
// The unit takes a new word in every cycle and never raises busy_o; each word gives one
// result word, shown with done_o for one cycle; values are Q16.16 at the default FracBits.
// The path to each result runs through the 32-stage square-root pipeline
// followed by the 32 + FracBits-stage divider in each lane, which every operation passes
// through so that results leave in order. The receiver cannot stall the unit.
`default_nettype none
module homogeneous_vector_alu import hva_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned NumBits = 32 + FracBits;

  typedef struct packed {
    logic [3:0]         func;
    logic [3:0][31:0]   r;
    logic signed [31:0] sc;
    logic               sat;
    logic               is_point;
    logic               is_vec;
    logic               s_zero;
    logic               s_neg;
    logic [31:0]        s_abs;
    logic [3:0]         a_neg;
    logic [3:0][31:0]   a_abs;
  } meta_t;

  logic accept;
  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  logic signed [31:0] m1a [4], m1b [4], m2a [4], m2b [4];
  logic signed [65:0] raw [4], rnd [4];
  logic [63:0]        sq [4];

  logic  v1_q, v2_q, v3_q;
  req_t  req1_q, req2_q;
  meta_t meta_d, meta3_q;
  logic [63:0] sumsq_d, sumsq_q;

  logic [SqrtStages-1:0] vl1_q;
  meta_t                 line1_q [SqrtStages];
  logic [NumBits-1:0]    vl2_q;
  meta_t                 line2_q [NumBits];
  logic [31:0]           root2_q [NumBits];
  logic [31:0]           root;
  logic [32:0]           den;
  logic [NumBits-1:0]    quo [4];

  logic done_q;
  rsp_t rsp_d, rsp_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign av[0] = req_i.a_x;
  assign av[1] = req_i.a_y;
  assign av[2] = req_i.a_z;
  assign av[3] = req_i.a_w;
  assign bv[0] = req_i.b_x;
  assign bv[1] = req_i.b_y;
  assign bv[2] = req_i.b_z;
  assign bv[3] = req_i.b_w;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    always_comb begin
      m2a[i] = av[(i + 2) % 3];
      m2b[i] = bv[(i + 1) % 3];
      case (req_i.func)
        FUNC_SCALE: begin
          m1a[i] = av[i];
          m1b[i] = req_i.scale_value;
        end
        FUNC_DOT: begin
          m1a[i] = av[i];
          m1b[i] = bv[i];
        end
        FUNC_CROSS: begin
          m1a[i] = av[(i + 1) % 3];
          m1b[i] = bv[(i + 2) % 3];
        end
        default: begin
          m1a[i] = av[i];
          m1b[i] = av[i];
        end
      endcase
    end

    hva_lane #(.FracBits(FracBits)) u_lane (
      .clk_i (clk_i),
      .func_i(req_i.func),
      .a_i   (av[i]),
      .b_i   (bv[i]),
      .m1a_i (m1a[i]),
      .m1b_i (m1b[i]),
      .m2a_i (m2a[i]),
      .m2b_i (m2b[i]),
      .raw_o (raw[i]),
      .rnd_o (rnd[i]),
      .sq_o  (sq[i])
    );
  end

  always_ff @(posedge clk_i) begin
    req1_q <= req_i;
    req2_q <= req1_q;
  end

  always_comb begin
    logic signed [31:0] a2 [4];
    logic signed [65:0] dot;
    logic [64:0]        sum;
    clip_t              c;
    a2[0] = req2_q.a_x;
    a2[1] = req2_q.a_y;
    a2[2] = req2_q.a_z;
    a2[3] = req2_q.a_w;
    meta_d = '0;
    meta_d.func = req2_q.func;
    for (int i = 0; i < 4; i++) begin
      c = clip66(raw[i]);
      if (!(i == 3 && req2_q.func == FUNC_CROSS)) begin
        meta_d.r[i] = c.val;
        meta_d.sat  = meta_d.sat | c.sat;
      end
      meta_d.a_neg[i] = a2[i][31];
      meta_d.a_abs[i] = a2[i][31] ? 32'(-a2[i]) : 32'(a2[i]);
    end
    dot = (rnd[0] + rnd[1]) + (rnd[2] + rnd[3]);
    if (req2_q.func == FUNC_DOT) begin
      c = clip66(dot);
      meta_d.sc  = c.val;
      meta_d.sat = c.sat;
    end
    meta_d.is_point = req2_q.a_w == 32'(64'd1 << FracBits);
    meta_d.is_vec   = req2_q.a_w == '0;
    meta_d.s_zero   = req2_q.scale_value == '0;
    meta_d.s_neg    = req2_q.scale_value[31];
    meta_d.s_abs    = req2_q.scale_value[31] ? 32'(-req2_q.scale_value)
                                             : 32'(req2_q.scale_value);
    sum = (65'(sq[0]) + 65'(sq[1])) + (65'(sq[2]) + 65'(sq[3]));
    sumsq_d = sum[64] ? '1 : sum[63:0];
  end

  always_ff @(posedge clk_i) begin
    meta3_q <= meta_d;
    sumsq_q <= sumsq_d;
  end

  hva_sqrt u_sqrt (
    .clk_i (clk_i),
    .n_i   (sumsq_q),
    .root_o(root)
  );

  always_ff @(posedge clk_i) begin
    line1_q[0] <= meta3_q;
    for (int k = 1; k < SqrtStages; k++) begin
      line1_q[k] <= line1_q[k-1];
    end
    line2_q[0] <= line1_q[SqrtStages-1];
    root2_q[0] <= root;
    for (int k = 1; k < NumBits; k++) begin
      line2_q[k] <= line2_q[k-1];
      root2_q[k] <= root2_q[k-1];
    end
  end

  assign den = (line1_q[SqrtStages-1].func == FUNC_NORM) ? {1'b0, root}
                                                         : {1'b0, line1_q[SqrtStages-1].s_abs};

  for (genvar i = 0; i < 4; i++) begin : g_div
    hva_div #(.NumBits(NumBits)) u_div (
      .clk_i(clk_i),
      .num_i({line1_q[SqrtStages-1].a_abs[i], {FracBits{1'b0}}}),
      .den_i(den),
      .quo_o(quo[i])
    );
  end

  always_comb begin
    meta_t              m;
    logic [31:0]        mag;
    logic signed [31:0] r [4];
    logic signed [31:0] sc;
    logic               sat, zdiv, neg, msat;
    logic [NumBits-1:0] lim;
    m    = line2_q[NumBits-1];
    mag  = root2_q[NumBits-1];
    sat  = m.sat;
    zdiv = 1'b0;
    sc   = m.sc;
    msat = mag[31];
    for (int i = 0; i < 4; i++) begin
      r[i] = m.r[i];
    end
    case (m.func)
      FUNC_DIV, FUNC_NORM: begin
        sat = 1'b0;
        sc  = '0;
        if ((m.func == FUNC_DIV && m.s_zero) || (m.func == FUNC_NORM && mag == '0)) begin
          zdiv = 1'b1;
          for (int i = 0; i < 4; i++) begin
            r[i] = '0;
          end
        end else begin
          for (int i = 0; i < 4; i++) begin
            neg = m.a_neg[i] ^ (m.func == FUNC_DIV && m.s_neg);
            lim = neg ? NumBits'(64'h80000000) : NumBits'(64'h7FFFFFFF);
            if (quo[i] > lim) begin
              sat  = 1'b1;
              r[i] = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else begin
              r[i] = neg ? -$signed(quo[i][31:0]) : $signed(quo[i][31:0]);
            end
          end
          if (m.func == FUNC_NORM) begin
            sc  = msat ? 32'sh7FFFFFFF : $signed(mag);
            sat = sat | msat;
          end
        end
      end
      FUNC_MAG: begin
        sc  = msat ? 32'sh7FFFFFFF : $signed(mag);
        sat = msat;
      end
      default: ;
    endcase
    rsp_d.r_x         = r[0];
    rsp_d.r_y         = r[1];
    rsp_d.r_z         = r[2];
    rsp_d.r_w         = r[3];
    rsp_d.scalar_out  = sc;
    rsp_d.a_is_point  = m.is_point;
    rsp_d.a_is_vector = m.is_vec;
    rsp_d.zero_divide = zdiv;
    rsp_d.saturated   = sat;
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vl1_q  <= '0;
      vl2_q  <= '0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vl1_q  <= {vl1_q[SqrtStages-2:0], v3_q};
      vl2_q  <= {vl2_q[NumBits-2:0], vl1_q[SqrtStages-1]};
      done_q <= vl2_q[NumBits-1];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/hva_checker.sv =====
// Port-level checks for the homogeneous vector ALU and their binding.
`default_nettype none
module hva_checker import hva_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  localparam int unsigned Latency = 68 + FracBits;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start_i && !busy_o, Latency) |-> done_o)
    else $error("A word taken did not give its result on time.");

  a_cross_w : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start_i, Latency) && $past(req_i.func == FUNC_CROSS, Latency))
    |-> rsp_o.r_w == '0)
    else $error("A cross product gave a non-zero w.");

  a_zdiv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.zero_divide) |-> (rsp_o.r_x == '0 && rsp_o.r_y == '0 &&
      rsp_o.r_z == '0 && rsp_o.r_w == '0 && rsp_o.scalar_out == '0 && !rsp_o.saturated))
    else $error("A zero divisor left non-zero results.");

  a_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.a_is_point && rsp_o.a_is_vector))
    else $error("Operand a was flagged as both point and vector.");

endmodule

bind homogeneous_vector_alu hva_checker #(.FracBits(FracBits)) u_hva_checker (.*);
`default_nettype wire
